[hdl/pdma_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and sequencer states of the motion accumulator.
package pdma_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    FUNC_MOTION      = 2'd0,
    FUNC_FRAME       = 2'd1,
    FUNC_PAIR_LEFT   = 2'd2,
    FUNC_PAIR_RIGHT  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_ADD_X,
    ST_ADD_Y,
    ST_APPEND,
    ST_CLEAR,
    ST_REPORT,
    ST_EMIT
  } state_t;

  // Button transition flag bits
  localparam int BTN_PRI_DOWN = 0;
  localparam int BTN_PRI_UP   = 1;
  localparam int BTN_SEC_DOWN = 2;
  localparam int BTN_SEC_UP   = 3;

  localparam logic signed [31:0] SUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SUM_MIN = 32'sh8000_0000;

endpackage

[hdl/pdma_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels: input event words and role report words.
interface pdma_evt_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [15:0]        device_id;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  logic [15:0]        button_flags;

  modport source (output valid, func, device_id, delta_x, delta_y, button_flags,
                  input ready);
  modport sink (input valid, func, device_id, delta_x, delta_y, button_flags,
                output ready);
endinterface

interface pdma_rpt_if;
  logic               valid;
  logic               ready;
  logic               left_assigned;
  logic               left_found;
  logic signed [31:0] left_sum_x;
  logic signed [31:0] left_sum_y;
  logic               left_primary_down;
  logic               left_secondary_down;
  logic               right_assigned;
  logic               right_found;
  logic signed [31:0] right_sum_x;
  logic signed [31:0] right_sum_y;
  logic               right_primary_down;
  logic               right_secondary_down;

  modport source (output valid, left_assigned, left_found, left_sum_x, left_sum_y,
                  left_primary_down, left_secondary_down, right_assigned,
                  right_found, right_sum_x, right_sum_y, right_primary_down,
                  right_secondary_down,
                  input ready);
  modport sink (input valid, left_assigned, left_found, left_sum_x, left_sum_y,
                left_primary_down, left_secondary_down, right_assigned,
                right_found, right_sum_x, right_sum_y, right_primary_down,
                right_secondary_down,
                output ready);
endinterface

[hdl/per_device_motion_accumulator.sv]
`timescale 1ns / 1ps
// Per-device motion accumulator: device table, pairing roles and role report.
//
// Keeps a table of up to TABLE_ENTRIES pointing devices (package constant),
// each with saturating 32-bit x/y motion sums and primary/secondary held bits.
// One word on evt is one of: motion event, frame start (clears all sums),
// start left pairing or start right pairing. Every accepted word yields exactly
// one report word on rpt with the state of the devices bound to the left and
// right roles, taken after the word's update. Work is done by a small sequencer
// that steps through the table one entry per cycle and shares one saturating
// 32-bit adder between the x and y sums. evt.ready is high only while the
// sequencer is idle; a finished report sits in the rpt output register, so the
// next word can be taken while that report waits.
// Steps per word: a motion word walks the table to find its device, then
// either updates the x and y sums, appends a new entry, or (table full) does
// neither; a frame start walks the table clearing sums; a pairing start goes
// straight on. Every word then walks the table once more to build the
// report, and ends in the emit state. The longest word is a motion hit on the
// last entry of a full table. There is no clearing pass after reset.
module per_device_motion_accumulator (
  input  logic         clk,
  input  logic         rst,
  pdma_evt_if.sink     evt,
  pdma_rpt_if.source   rpt
);
  import pdma_pkg::*;

  // Device table (only entries below count are ever read)
  logic [15:0]        entry_id        [TABLE_ENTRIES];
  logic signed [31:0] entry_sum_x     [TABLE_ENTRIES];
  logic signed [31:0] entry_sum_y     [TABLE_ENTRIES];
  logic               entry_primary   [TABLE_ENTRIES];
  logic               entry_secondary [TABLE_ENTRIES];
  logic [CNT_W-1:0]   count;

  // Roles and pairing
  logic [15:0] left_role_id;
  logic [15:0] right_role_id;
  logic        pair_left;
  logic        pair_right;

  // Sequencer
  state_t           state, state_next;
  logic [CNT_W-1:0] scan;
  logic [IDX_W-1:0] idx;
  logic             scan_done;

  // Latched word
  logic [15:0]        cur_id;
  logic signed [15:0] cur_dx;
  logic signed [15:0] cur_dy;
  logic [3:0]         cur_flags;

  // Report being built
  logic               rep_l_found, rep_r_found;
  logic signed [31:0] rep_l_x, rep_l_y, rep_r_x, rep_r_y;
  logic               rep_l_pri, rep_l_sec, rep_r_pri, rep_r_sec;

  // Output register
  logic               out_valid;
  logic               out_l_asg, out_l_found, out_l_pri, out_l_sec;
  logic               out_r_asg, out_r_found, out_r_pri, out_r_sec;
  logic signed [31:0] out_l_x, out_l_y, out_r_x, out_r_y;

  // Control strobes
  logic accept, do_add_x, do_add_y, do_append, do_clear, scan_inc, scan_clr;
  logic rep_cap, load_out, id_hit;

  // Shared saturating adder
  logic signed [31:0] add_a, add_b, add_res;
  logic signed [32:0] add_wide;

  assign idx       = scan[IDX_W-1:0];
  assign scan_done = (scan == count);
  assign id_hit    = (entry_id[idx] == cur_id);
  assign accept    = evt.valid && evt.ready;
  assign evt.ready = (state == ST_IDLE);

  always_comb begin
    if (state == ST_ADD_Y) begin
      add_a = entry_sum_y[idx];
      add_b = 32'(cur_dy);
    end else begin
      add_a = entry_sum_x[idx];
      add_b = 32'(cur_dx);
    end
    add_wide = 33'(add_a) + 33'(add_b);
    // Overflow when the two top bits of the wide sum disagree
    if (add_wide[32] != add_wide[31]) begin
      add_res = add_wide[32] ? SUM_MIN : SUM_MAX;
    end else begin
      add_res = add_wide[31:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (func_t'(evt.func))
            FUNC_MOTION: state_next = ST_LOOKUP;
            FUNC_FRAME:  state_next = ST_CLEAR;
            default:     state_next = ST_REPORT;
          endcase
        end
      end
      ST_LOOKUP: begin
        if (scan_done) begin
          state_next = (count < CNT_W'(TABLE_ENTRIES)) ? ST_APPEND : ST_REPORT;
        end else if (id_hit) begin
          state_next = ST_ADD_X;
        end
      end
      ST_ADD_X:  state_next = ST_ADD_Y;
      ST_ADD_Y:  state_next = ST_REPORT;
      ST_APPEND: state_next = ST_REPORT;
      ST_CLEAR: begin
        if (scan_done) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (scan_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || rpt.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Strobes
  always_comb begin
    do_add_x  = 1'b0;
    do_add_y  = 1'b0;
    do_append = 1'b0;
    do_clear  = 1'b0;
    scan_inc  = 1'b0;
    scan_clr  = 1'b0;
    rep_cap   = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE:   scan_clr = accept;
      ST_LOOKUP: begin
        if (scan_done) begin
          do_append = (count < CNT_W'(TABLE_ENTRIES));
          scan_clr  = 1'b1;
        end else if (!id_hit) begin
          scan_inc = 1'b1;
        end
      end
      ST_ADD_X:  do_add_x = 1'b1;
      ST_ADD_Y: begin
        do_add_y = 1'b1;
        scan_clr = 1'b1;
      end
      ST_APPEND: scan_clr = 1'b1;
      ST_CLEAR: begin
        if (scan_done) begin
          scan_clr = 1'b1;
        end else begin
          do_clear = 1'b1;
          scan_inc = 1'b1;
        end
      end
      ST_REPORT: begin
        if (!scan_done) begin
          rep_cap  = 1'b1;
          scan_inc = 1'b1;
        end
      end
      ST_EMIT:   load_out = !out_valid || rpt.ready;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      scan          <= '0;
      count         <= '0;
      left_role_id  <= '0;
      right_role_id <= '0;
      pair_left     <= 1'b0;
      pair_right    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (scan_clr) begin
        scan <= '0;
      end else if (scan_inc) begin
        scan <= scan + 1'b1;
      end
      // Append happens from the lookup state, scan already equals count
      if (do_append) begin
        count <= count + 1'b1;
      end
      if (accept) begin
        case (func_t'(evt.func))
          FUNC_MOTION: begin
            // Left claim first; a right claim of the same id is then refused
            if (pair_left && evt.device_id != '0 && evt.device_id != right_role_id) begin
              left_role_id <= evt.device_id;
              pair_left    <= 1'b0;
            end else if (pair_right && evt.device_id != '0
                         && evt.device_id != left_role_id) begin
              right_role_id <= evt.device_id;
              pair_right    <= 1'b0;
            end
          end
          FUNC_FRAME: ;
          FUNC_PAIR_LEFT: begin
            pair_left  <= 1'b1;
            pair_right <= 1'b0;
          end
          default: begin
            pair_left  <= 1'b0;
            pair_right <= 1'b1;
          end
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rpt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Table and payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_id    <= evt.device_id;
      cur_dx    <= evt.delta_x;
      cur_dy    <= evt.delta_y;
      cur_flags <= evt.button_flags[3:0];
    end
    if (do_add_x) begin
      entry_sum_x[idx] <= add_res;
      // An up bit wins over a down bit
      if (cur_flags[BTN_PRI_UP]) begin
        entry_primary[idx] <= 1'b0;
      end else if (cur_flags[BTN_PRI_DOWN]) begin
        entry_primary[idx] <= 1'b1;
      end
      if (cur_flags[BTN_SEC_UP]) begin
        entry_secondary[idx] <= 1'b0;
      end else if (cur_flags[BTN_SEC_DOWN]) begin
        entry_secondary[idx] <= 1'b1;
      end
    end
    if (do_add_y) begin
      entry_sum_y[idx] <= add_res;
    end
    if (do_append) begin
      entry_id[idx]        <= cur_id;
      entry_sum_x[idx]     <= 32'(cur_dx);
      entry_sum_y[idx]     <= 32'(cur_dy);
      entry_primary[idx]   <= cur_flags[BTN_PRI_DOWN];
      entry_secondary[idx] <= cur_flags[BTN_SEC_DOWN];
    end
    if (do_clear) begin
      entry_sum_x[idx] <= '0;
      entry_sum_y[idx] <= '0;
    end

    // Report walk: ids in the table are unique, so at most one match per role
    if (scan_clr) begin
      rep_l_found <= 1'b0;
      rep_l_x     <= '0;
      rep_l_y     <= '0;
      rep_l_pri   <= 1'b0;
      rep_l_sec   <= 1'b0;
      rep_r_found <= 1'b0;
      rep_r_x     <= '0;
      rep_r_y     <= '0;
      rep_r_pri   <= 1'b0;
      rep_r_sec   <= 1'b0;
    end else if (rep_cap) begin
      if (left_role_id != '0 && entry_id[idx] == left_role_id) begin
        rep_l_found <= 1'b1;
        rep_l_x     <= entry_sum_x[idx];
        rep_l_y     <= entry_sum_y[idx];
        rep_l_pri   <= entry_primary[idx];
        rep_l_sec   <= entry_secondary[idx];
      end
      if (right_role_id != '0 && entry_id[idx] == right_role_id) begin
        rep_r_found <= 1'b1;
        rep_r_x     <= entry_sum_x[idx];
        rep_r_y     <= entry_sum_y[idx];
        rep_r_pri   <= entry_primary[idx];
        rep_r_sec   <= entry_secondary[idx];
      end
    end

    if (load_out) begin
      out_l_asg   <= (left_role_id != '0);
      out_l_found <= rep_l_found;
      out_l_x     <= rep_l_x;
      out_l_y     <= rep_l_y;
      out_l_pri   <= rep_l_pri;
      out_l_sec   <= rep_l_sec;
      out_r_asg   <= (right_role_id != '0);
      out_r_found <= rep_r_found;
      out_r_x     <= rep_r_x;
      out_r_y     <= rep_r_y;
      out_r_pri   <= rep_r_pri;
      out_r_sec   <= rep_r_sec;
    end
  end

  assign rpt.valid                = out_valid;
  assign rpt.left_assigned        = out_l_asg;
  assign rpt.left_found           = out_l_found;
  assign rpt.left_sum_x           = out_l_x;
  assign rpt.left_sum_y           = out_l_y;
  assign rpt.left_primary_down    = out_l_pri;
  assign rpt.left_secondary_down  = out_l_sec;
  assign rpt.right_assigned       = out_r_asg;
  assign rpt.right_found          = out_r_found;
  assign rpt.right_sum_x          = out_r_x;
  assign rpt.right_sum_y          = out_r_y;
  assign rpt.right_primary_down   = out_r_pri;
  assign rpt.right_secondary_down = out_r_sec;

endmodule
